// File: rtl/pkbb_pkg.sv
// ============================================================================
// pkbb_pkg: shared types and constants of the cross mean filter
// Pixel and configuration types, register indexes and field widths.
// ============================================================================
package pkbb_pkg;

    // Field widths
    localparam int CHAN_W    = 8;
    localparam int DIM_W     = 11;
    localparam int CFG_IDX_W = 3;
    localparam int SUM3_W    = 10;
    // Wide enough for every column, width and region compare at any MAX_WIDTH below 8192
    localparam int CMP_W     = 13;

    // Channel slots inside a packed pixel
    localparam int CH_RED   = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 0;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_RIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BOTTOM = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLUR_ENABLE   = 3'd6;

    // Reset values
    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 11'd720;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 11'd540;

    typedef logic [2:0][CHAN_W-1:0] t_pix;
    typedef logic [2:0][SUM3_W-1:0] t_sum3;

    typedef struct packed {
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
        logic [DIM_W-1:0] region_left;
        logic [DIM_W-1:0] region_top;
        logic [DIM_W-1:0] region_right;
        logic [DIM_W-1:0] region_bottom;
        logic             blur_enable;
    } t_cfg;

    // One pixel between the store read and the mean stage
    typedef struct packed {
        t_pix  centre;
        t_sum3 sum3;       // centre + left + below, per channel
        logic  last_col;   // right neighbour is the centre itself
        logic  top_row;    // above neighbour is the centre itself
        logic  blur_on;    // blur this pixel
        logic  frame_end;
    } t_stage;

endpackage

// File: rtl/pkbb_if.sv
// ============================================================================
// pkbb_if: request channels of the cross mean filter
// Input pixel, output pixel and configuration write channels.
// ============================================================================
interface pkbb_pix_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       flush;

    modport source (output valid, output red, output green, output blue, output flush,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input flush,
                    output ready);
endinterface

interface pkbb_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output frame_end, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input frame_end, output ready);
endinterface

interface pkbb_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pkbb_pkg::CFG_IDX_W-1:0]    index;
    logic [pkbb_pkg::DIM_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/plus_kernel_box_blur_unit.sv
// ============================================================================
// plus_kernel_box_blur_unit: five-point cross mean filter
// Raster-order RGB stream; centre, left, right, above and below are averaged.
// ============================================================================
// Usage:
//   i_pix takes one pixel per request in raster order. After the last row of
//   a frame, send one row of filler requests (frame_width of them) to drain
//   it; the flush bit is not looked at, the row position decides.
//   o_pix returns the pixel one row behind the input: blurred inside the
//   region while blur is enabled, unchanged elsewhere. frame_end marks the
//   last pixel of a frame. Requests of the first row return nothing.
//   i_cfg writes one register per request and is always ready; write only
//   while the block is idle.
// Timing:
//   One pixel per clock sustained while o_pix is ready. A result reaches the
//   output register through the staged pixel (store read, then the mean stage).
//   The rate is set by the two line stores, each read and written once per
//   accepted pixel.
// Reset and stall:
//   Reset clears the column and row counters and loads the register reset
//   values; the line stores are not cleared. When o_pix stalls, the output
//   register and one staged pixel hold, then i_pix ready drops.
// ============================================================================
module plus_kernel_box_blur_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pkbb_pix_in_if.sink     i_pix,
    pkbb_pix_out_if.source  o_pix,
    pkbb_cfg_if.sink        i_cfg
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int CMP_W = pkbb_pkg::CMP_W;
    localparam int DIM_W = pkbb_pkg::DIM_W;

    pkbb_pkg::t_cfg   cfg;

    // Scan position
    logic [CW-1:0]    r_col;
    logic [DIM_W-1:0] r_row;

    // Centre of the previous pixel: the left neighbour
    pkbb_pkg::t_pix   r_prev_centre;

    // Forward a centre-store write that hit the address being prefetched
    logic             r_fwd;
    pkbb_pkg::t_pix   r_fwd_pix;

    // Staged pixel waiting for its right and above store data
    logic             r_s1_valid;
    pkbb_pkg::t_stage r_s1;
    pkbb_pkg::t_stage n_s1;

    logic             accept;
    logic             take;
    logic [CMP_W-1:0] w_eff;
    logic [CMP_W-1:0] col_next;
    logic [DIM_W-1:0] h_eff;
    logic [DIM_W-1:0] out_row;
    logic             last_col;
    logic             flush_row;
    logic             in_region;
    logic [CW-1:0]    cen_raddr;
    pkbb_pkg::t_pix   pix;
    pkbb_pkg::t_pix   cen_q;
    pkbb_pkg::t_pix   abv_q;
    pkbb_pkg::t_pix   centre;
    pkbb_pkg::t_pix   left;
    pkbb_pkg::t_pix   below;

    pkbb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    assign accept      = i_pix.valid && i_pix.ready;
    assign i_pix.ready = !r_s1_valid || take;

    assign pix[pkbb_pkg::CH_RED]   = i_pix.red;
    assign pix[pkbb_pkg::CH_GREEN] = i_pix.green;
    assign pix[pkbb_pkg::CH_BLUE]  = i_pix.blue;

    always_comb begin
        // Clamp the geometry: width to 1..MAX_WIDTH, height to at least 1
        if (cfg.frame_width == '0) begin
            w_eff = CMP_W'(1);
        end else if (CMP_W'(cfg.frame_width) > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = CMP_W'(cfg.frame_width);
        end
        h_eff     = (cfg.frame_height == '0) ? DIM_W'(1) : cfg.frame_height;

        col_next  = CMP_W'(r_col) + CMP_W'(1);
        last_col  = col_next >= w_eff;
        flush_row = r_row >= h_eff;
        out_row   = r_row - DIM_W'(1);

        // Prefetch the centre of the next position; it is also this pixel's right
        cen_raddr = last_col ? '0 : col_next[CW-1:0];

        centre = r_fwd ? r_fwd_pix : cen_q;
        left   = (r_col != '0) ? r_prev_centre : centre;
        below  = flush_row ? centre : pix;

        in_region = cfg.blur_enable
                 && CMP_W'(r_col) >= CMP_W'(cfg.region_left)
                 && CMP_W'(r_col) <  CMP_W'(cfg.region_right)
                 && out_row >= cfg.region_top
                 && out_row <  cfg.region_bottom;

        n_s1.centre = centre;
        for (int ch = 0; ch < 3; ch++) begin
            n_s1.sum3[ch] = pkbb_pkg::SUM3_W'(centre[ch]) + pkbb_pkg::SUM3_W'(left[ch])
                          + pkbb_pkg::SUM3_W'(below[ch]);
        end
        n_s1.last_col  = last_col;
        n_s1.top_row   = (out_row == '0);
        n_s1.blur_on   = in_region;
        n_s1.frame_end = flush_row && last_col;
    end

    // Centre row store: written with the new centre, read one position ahead
    pkbb_ram #(
        .WIDTH (24),
        .DEPTH (MAX_WIDTH)
    ) u_cen_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata (below),
        .i_re    (accept),
        .i_raddr (cen_raddr),
        .o_rdata (cen_q)
    );

    // Above row store: takes the old centre, read at the current position
    pkbb_ram #(
        .WIDTH (24),
        .DEPTH (MAX_WIDTH)
    ) u_abv_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata (centre),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (abv_q)
    );

    pkbb_mean u_mean (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (r_s1_valid),
        .i_s1       (r_s1),
        .i_right_q  (cen_q),
        .i_above_q  (abv_q),
        .o_take     (take),
        .o_pix      (o_pix)
    );

    // Control: counters, stage valid, forward flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (accept) begin
                r_fwd <= (cen_raddr == r_col);
                if (last_col) begin
                    r_col <= '0;
                    r_row <= flush_row ? '0 : r_row + DIM_W'(1);
                end else begin
                    r_col <= col_next[CW-1:0];
                end
            end
            // First-row pixels only fill the stores
            if (accept) begin
                r_s1_valid <= (r_row != '0);
            end else if (take) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Payload: advance on every accepted request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev_centre <= centre;
            r_fwd_pix     <= below;
            r_s1          <= n_s1;
        end
    end

endmodule

// File: rtl/pkbb_ram.sv
// ============================================================================
// pkbb_ram: generic single-clock RAM
// One write port, one read port, registered read data, read-first.
// ============================================================================
module pkbb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/pkbb_cfg.sv
// ============================================================================
// pkbb_cfg: configuration register file
// Takes register writes from the configuration channel, always ready.
// ============================================================================
module pkbb_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pkbb_cfg_if.sink        i_cfg,
    output pkbb_pkg::t_cfg  o_cfg
);

    pkbb_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width   <= pkbb_pkg::RST_FRAME_WIDTH;
            r_cfg.frame_height  <= pkbb_pkg::RST_FRAME_HEIGHT;
            r_cfg.region_left   <= '0;
            r_cfg.region_top    <= '0;
            r_cfg.region_right  <= '0;
            r_cfg.region_bottom <= '0;
            r_cfg.blur_enable   <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                pkbb_pkg::REG_FRAME_WIDTH:   r_cfg.frame_width   <= i_cfg.data;
                pkbb_pkg::REG_FRAME_HEIGHT:  r_cfg.frame_height  <= i_cfg.data;
                pkbb_pkg::REG_REGION_LEFT:   r_cfg.region_left   <= i_cfg.data;
                pkbb_pkg::REG_REGION_TOP:    r_cfg.region_top    <= i_cfg.data;
                pkbb_pkg::REG_REGION_RIGHT:  r_cfg.region_right  <= i_cfg.data;
                pkbb_pkg::REG_REGION_BOTTOM: r_cfg.region_bottom <= i_cfg.data;
                pkbb_pkg::REG_BLUR_ENABLE:   r_cfg.blur_enable   <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

endmodule

// File: rtl/pkbb_mean.sv
// ============================================================================
// pkbb_mean: five-point mean and output register
// Adds the right and above neighbours, divides by five, drives the output.
// ============================================================================
module pkbb_mean (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s1_valid,
    input  pkbb_pkg::t_stage  i_s1,
    input  pkbb_pkg::t_pix    i_right_q,
    input  pkbb_pkg::t_pix    i_above_q,
    output logic              o_take,
    pkbb_pix_out_if.source    o_pix
);

    // floor(s / 5) for s < 2048 as (s * 13108) >> 16
    localparam int          PROD_W = 25;
    localparam logic [13:0] RECIP  = 14'd13108;

    logic             r_out_valid;
    logic             r_out_end;
    pkbb_pkg::t_pix   r_out_pix;

    pkbb_pkg::t_pix   right;
    pkbb_pkg::t_pix   above;
    pkbb_pkg::t_pix   mean;
    pkbb_pkg::t_pix   n_out_pix;
    logic [10:0]      sum5 [3];
    logic [PROD_W-1:0] prod [3];

    assign o_take = i_s1_valid && (!r_out_valid || o_pix.ready);

    always_comb begin
        right = i_s1.last_col ? i_s1.centre : i_right_q;
        above = i_s1.top_row  ? i_s1.centre : i_above_q;
        for (int ch = 0; ch < 3; ch++) begin
            sum5[ch] = 11'(i_s1.sum3[ch]) + 11'(right[ch]) + 11'(above[ch]);
            prod[ch] = PROD_W'(sum5[ch]) * PROD_W'(RECIP);
            mean[ch] = prod[ch][23:16];
        end
        n_out_pix = i_s1.blur_on ? mean : i_s1.centre;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out_pix <= n_out_pix;
            r_out_end <= i_s1.frame_end;
        end
    end

    assign o_pix.valid     = r_out_valid;
    assign o_pix.out_red   = r_out_pix[pkbb_pkg::CH_RED];
    assign o_pix.out_green = r_out_pix[pkbb_pkg::CH_GREEN];
    assign o_pix.out_blue  = r_out_pix[pkbb_pkg::CH_BLUE];
    assign o_pix.frame_end = r_out_end;

endmodule

// File: bench/tb_plus_kernel_box_blur_unit.sv
// ============================================================================
// tb_plus_kernel_box_blur_unit: self-checking bench of the cross mean filter
// Streams whole frames through the filter under changing geometry, region and
// flow control. A predictor keeps its own line stores and counters, works out
// each output pixel and the result is compared field by field on arrival.
// ============================================================================
module tb_plus_kernel_box_blur_unit;

    localparam int CHAN_W    = pkbb_pkg::CHAN_W;
    localparam int DIM_W     = pkbb_pkg::DIM_W;
    localparam int CFG_IDX_W = pkbb_pkg::CFG_IDX_W;
    localparam int CH_RED    = pkbb_pkg::CH_RED;
    localparam int CH_GREEN  = pkbb_pkg::CH_GREEN;
    localparam int CH_BLUE   = pkbb_pkg::CH_BLUE;

    typedef pkbb_pkg::t_pix t_pix;
    typedef pkbb_pkg::t_cfg t_cfg;

    localparam int MAX_W       = 1024;
    localparam int MEAN_DIV    = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYC  = 8;      // output register plus one staged pixel, with margin
    localparam int TAIL_CYC    = 16;
    localparam int HOLD_CYC    = 300;
    localparam int REPORT_MAX  = 10;
    localparam int NO_ROW      = -1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              frame_end;
    } t_out_px;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pkbb_pix_in_if  pix_in_bus ();
    pkbb_pix_out_if pix_out_bus ();
    pkbb_cfg_if     cfg_bus ();

    plus_kernel_box_blur_unit #(
        .MAX_WIDTH (MAX_W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in_bus.sink),
        .o_pix   (pix_out_bus.source),
        .i_cfg   (cfg_bus.sink)
    );

    // Predictor state: its own registers, line stores and raster position
    t_cfg    shadow_cfg;
    t_pix    above_line [MAX_W];
    t_pix    centre_line [MAX_W];
    int      col_pos;
    int      row_pos;
    t_out_px expected_px_q [$];

    // Flow control knobs, in percent, and the receiver hold-off in cycles
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_left;

    int unsigned items_sent;
    int unsigned fail_count;
    int unsigned cycle_count;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: a long hold-off wins over the random stall
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            pix_out_bus.ready <= 1'b0;
            hold_left--;
        end else begin
            pix_out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted output request with the oldest prediction
    always @(posedge i_clk) begin
        t_out_px got;
        t_out_px want;
        if (i_rst_n === 1'b1 && pix_out_bus.valid === 1'b1 && pix_out_bus.ready === 1'b1) begin
            got.red       = pix_out_bus.out_red;
            got.green     = pix_out_bus.out_green;
            got.blue      = pix_out_bus.out_blue;
            got.frame_end = pix_out_bus.frame_end;
            if (expected_px_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected pixel at cycle %0d: r=%02h g=%02h b=%02h end=%0b",
                             cycle_count, got.red, got.green, got.blue, got.frame_end);
            end else begin
                want = expected_px_q.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.frame_end !== want.frame_end) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("mismatch cycle %0d: exp %02h %02h %02h %0b got %02h %02h %02h %0b",
                                 cycle_count, want.red, want.green, want.blue, want.frame_end,
                                 got.red, got.green, got.blue, got.frame_end);
                end
            end
        end
    end

    // Effective frame size: zero counts as one, width saturates at the store depth
    function automatic int frame_cols();
        int w;
        w = int'(shadow_cfg.frame_width);
        if (w == 0) w = 1;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic int frame_rows();
        int h;
        h = int'(shadow_cfg.frame_height);
        if (h == 0) h = 1;
        return h;
    endfunction

    // Advance the predictor by one accepted request and queue the pixel it releases.
    // The output is the centre-row pixel at this column, one row behind the input.
    function automatic void cross_mean_predict(input t_pix px);
        int   cols;
        int   k;
        int   sum;
        bit   last_col;
        bit   flush_row;
        bit   in_region;
        t_pix centre;
        t_pix above;
        t_pix below;
        t_pix west;
        t_pix east;
        t_pix mean;
        t_out_px want;
        cols      = frame_cols();
        last_col  = (col_pos + 1 >= cols);
        flush_row = (row_pos >= frame_rows());
        centre    = centre_line[col_pos];
        above     = above_line[col_pos];
        // the left neighbour already moved into the above line this row
        west      = (col_pos > 0) ? above_line[col_pos - 1] : centre;
        east      = last_col ? centre : centre_line[col_pos + 1];
        // position alone makes a filler: its data stands in for nothing
        below     = flush_row ? centre : px;
        if (row_pos > 0) begin
            // top row of the image replicates itself upward
            if (row_pos == 1) above = centre;
            in_region = shadow_cfg.blur_enable &&
                        col_pos >= int'(shadow_cfg.region_left) &&
                        col_pos < int'(shadow_cfg.region_right) &&
                        row_pos - 1 >= int'(shadow_cfg.region_top) &&
                        row_pos - 1 < int'(shadow_cfg.region_bottom);
            mean = centre;
            if (in_region) begin
                for (k = 0; k < 3; k++) begin
                    sum     = int'(centre[k]) + int'(west[k]) + int'(east[k])
                            + int'(above[k]) + int'(below[k]);
                    mean[k] = CHAN_W'(sum / MEAN_DIV);
                end
            end
            want.red       = mean[CH_RED];
            want.green     = mean[CH_GREEN];
            want.blue      = mean[CH_BLUE];
            want.frame_end = flush_row && last_col;
            expected_px_q.push_back(want);
        end
        above_line[col_pos]  = centre;
        centre_line[col_pos] = below;
        if (last_col) begin
            col_pos = 0;
            row_pos = flush_row ? 0 : ((row_pos + 1) & 'h7FF);
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    function automatic t_pix random_pixel();
        t_pix px;
        int   k;
        for (k = 0; k < 3; k++) begin
            case ($urandom_range(7))
                0:       px[k] = '0;
                1:       px[k] = '1;
                default: px[k] = CHAN_W'($urandom);
            endcase
        end
        return px;
    endfunction

    // Offer one pixel request; hold it until accepted, then leave valid up
    task automatic send_pixel(input t_pix px, input logic flush_bit);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            pix_in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_in_bus.valid <= 1'b1;
        pix_in_bus.red   <= px[CH_RED];
        pix_in_bus.green <= px[CH_GREEN];
        pix_in_bus.blue  <= px[CH_BLUE];
        pix_in_bus.flush <= flush_bit;
        do @(posedge i_clk); while (pix_in_bus.ready !== 1'b1);
        cross_mean_predict(px);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every predicted pixel has come back
    task automatic wait_results_drained();
        pix_in_bus.valid <= 1'b0;
        do @(posedge i_clk); while (expected_px_q.size() != 0);
        @(negedge i_clk);
    endtask

    task automatic settle();
        wait_results_drained();
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // Write all seven registers back to back, only once the filter is idle
    task automatic write_config(input t_cfg setting);
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [DIM_W-1:0]     value;
        int                   n;
        settle();
        for (n = int'(pkbb_pkg::REG_FRAME_WIDTH); n <= int'(pkbb_pkg::REG_BLUR_ENABLE); n++) begin
            reg_idx = CFG_IDX_W'(n);
            case (reg_idx)
                pkbb_pkg::REG_FRAME_WIDTH:   value = setting.frame_width;
                pkbb_pkg::REG_FRAME_HEIGHT:  value = setting.frame_height;
                pkbb_pkg::REG_REGION_LEFT:   value = setting.region_left;
                pkbb_pkg::REG_REGION_TOP:    value = setting.region_top;
                pkbb_pkg::REG_REGION_RIGHT:  value = setting.region_right;
                pkbb_pkg::REG_REGION_BOTTOM: value = setting.region_bottom;
                // only the low bit enables; scatter junk above it
                default: value = {(DIM_W-1)'($urandom), setting.blur_enable};
            endcase
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= reg_idx;
            cfg_bus.data  <= value;
            do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
            @(negedge i_clk);
        end
        cfg_bus.valid <= 1'b0;
        shadow_cfg = setting;
    endtask

    // Send one frame of random pixels plus its filler row. Flip the flush flag on
    // noise_pct of the requests; optionally start a receiver hold-off at the head
    // of one row and pause the sender until drained in the middle of another.
    task automatic send_frame(input int noise_pct, input int hold_row, input int drain_row);
        int   r;
        int   c;
        int   cols;
        int   rows_n;
        logic fl;
        cols   = frame_cols();
        rows_n = frame_rows();
        for (r = 0; r <= rows_n; r++) begin
            for (c = 0; c < cols; c++) begin
                if (r == hold_row && c == 0) hold_left = HOLD_CYC;
                if (r == drain_row && c == cols / 2) wait_results_drained();
                fl = (r == rows_n);
                if ($urandom_range(99) < noise_pct) fl = !fl;
                send_pixel(random_pixel(), fl);
            end
        end
    endtask

    function automatic t_cfg random_setting();
        t_cfg s;
        int   w;
        int   h;
        int   lo;
        if ($urandom_range(15) == 0) begin
            w = $urandom_range(33, 200);
            h = $urandom_range(1, 2);
        end else begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 6);
        end
        s.frame_width  = DIM_W'(w);
        s.frame_height = DIM_W'(h);
        if ($urandom_range(3) != 0) begin
            // mostly a proper rectangle, possibly touching or crossing the frame edge
            lo = $urandom_range(0, w - 1);
            s.region_left  = DIM_W'(lo);
            s.region_right = DIM_W'($urandom_range(lo + 1, w + 1));
            lo = $urandom_range(0, h - 1);
            s.region_top    = DIM_W'(lo);
            s.region_bottom = DIM_W'($urandom_range(lo + 1, h + 1));
        end else begin
            // otherwise anything, inverted and empty regions included
            s.region_left   = DIM_W'($urandom_range(0, w + 1));
            s.region_right  = DIM_W'($urandom_range(0, w + 1));
            s.region_top    = DIM_W'($urandom_range(0, h + 1));
            s.region_bottom = DIM_W'($urandom_range(0, h + 1));
        end
        if ($urandom_range(5) == 0) begin
            s.region_right  = DIM_W'($urandom);
            s.region_bottom = DIM_W'($urandom);
        end
        s.blur_enable = ($urandom_range(3) != 0);
        return s;
    endfunction

    // Small hand-built frames: edge replication, channel extremes, ignored
    // flush flag, zero sizes and an inverted region
    task automatic test_directed_cases();
        t_cfg setting;
        t_pix px;
        int   r;
        int   c;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // 4x3 checkerboard, whole frame blurred
        setting               = '0;
        setting.frame_width   = DIM_W'(4);
        setting.frame_height  = DIM_W'(3);
        setting.region_right  = DIM_W'(4);
        setting.region_bottom = DIM_W'(3);
        setting.blur_enable   = 1'b1;
        write_config(setting);
        for (r = 0; r < 3; r++) begin
            for (c = 0; c < 4; c++) begin
                px[CH_RED]   = ((r ^ c) & 1) ? 8'hFF : 8'h00;
                px[CH_GREEN] = ~px[CH_RED];
                px[CH_BLUE]  = CHAN_W'((r * 4 + c) * 8'h11);
                // a pixel flagged as filler still counts as a pixel
                send_pixel(px, (r == 1 && c == 2));
            end
        end
        // filler row: data ignored whichever way the flag points
        for (c = 0; c < 4; c++) send_pixel(random_pixel(), c != 0);

        // zero width and height mean a single pixel that is its own neighbour
        setting               = '0;
        setting.region_right  = DIM_W'(1);
        setting.region_bottom = DIM_W'(1);
        setting.blur_enable   = 1'b1;
        write_config(setting);
        send_pixel({8'hFF, 8'h00, 8'h80}, 1'b0);
        send_pixel(random_pixel(), 1'b1);

        // inverted region with blur on: everything passes
        setting               = '0;
        setting.frame_width   = DIM_W'(3);
        setting.frame_height  = DIM_W'(2);
        setting.region_left   = DIM_W'(3);
        setting.region_right  = DIM_W'(1);
        setting.region_top    = DIM_W'(2);
        setting.blur_enable   = 1'b1;
        write_config(setting);
        send_frame(0, NO_ROW, NO_ROW);
    endtask

    // A long single row and a tall single column
    task automatic test_size_extremes();
        t_cfg setting;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // one long row, region running past the right edge
        setting               = '0;
        setting.frame_width   = DIM_W'(96);
        setting.frame_height  = DIM_W'(1);
        setting.region_left   = DIM_W'(1);
        setting.region_right  = '1;
        setting.region_bottom = '1;
        setting.blur_enable   = 1'b1;
        write_config(setting);
        send_frame(5, NO_ROW, NO_ROW);

        // one column, lower half blurred
        setting               = '0;
        setting.frame_width   = DIM_W'(1);
        setting.frame_height  = DIM_W'(64);
        setting.region_top    = DIM_W'(32);
        setting.region_right  = DIM_W'(1);
        setting.region_bottom = '1;
        setting.blur_enable   = 1'b1;
        write_config(setting);
        send_frame(5, NO_ROW, NO_ROW);
    endtask

    // Fill the filter against a long receiver hold-off, then pause mid-frame
    task automatic test_backpressure();
        t_cfg setting;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        setting               = '0;
        setting.frame_width   = DIM_W'(16);
        setting.frame_height  = DIM_W'(6);
        setting.region_left   = DIM_W'(1);
        setting.region_top    = DIM_W'(1);
        setting.region_right  = DIM_W'(15);
        setting.region_bottom = DIM_W'(5);
        setting.blur_enable   = 1'b1;
        write_config(setting);
        send_frame(0, 2, 4);
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                       input int unsigned budget);
        int unsigned first;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first          = items_sent;
        while (items_sent - first < budget) begin
            write_config(random_setting());
            send_frame(10, NO_ROW, NO_ROW);
        end
    endtask

    initial begin
        int r;
        i_rst_n                = 1'b0;
        pix_in_bus.valid       = 1'b0;
        pix_in_bus.red         = '0;
        pix_in_bus.green       = '0;
        pix_in_bus.blue        = '0;
        pix_in_bus.flush       = 1'b0;
        pix_out_bus.ready      = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = pkbb_pkg::REG_FRAME_WIDTH;
        cfg_bus.data           = '0;
        send_idle_pct          = 0;
        recv_stall_pct         = 0;
        hold_left              = 0;
        items_sent             = 0;
        fail_count             = 0;
        cycle_count            = 0;

        // reset values of the registers and counters; the predictor's own stores start at zero
        shadow_cfg              = '0;
        shadow_cfg.frame_width  = pkbb_pkg::RST_FRAME_WIDTH;
        shadow_cfg.frame_height = pkbb_pkg::RST_FRAME_HEIGHT;
        for (r = 0; r < MAX_W; r++) begin
            above_line[r]  = '0;
            centre_line[r] = '0;
        end
        col_pos = 0;
        row_pos = 0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_size_extremes();
        test_backpressure();
        test_random_traffic(0, 0, 180);
        test_random_traffic(81, 0, 180);
        test_random_traffic(0, 81, 180);
        test_random_traffic(10, 10, 180);

        settle();
        repeat (TAIL_CYC) @(posedge i_clk);
        if (fail_count == 0 && expected_px_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
